// ----- design/fdl_pkg.sv -----
// Shared constants, state codes and a helper function for the directory entry decoder.
`default_nettype none
package fdl_pkg;
  localparam int MAX_NAME_ENTRIES = 20;
  localparam int UNITS_PER_ENTRY = 13;
  localparam int STORE_DEPTH = MAX_NAME_ENTRIES * UNITS_PER_ENTRY;
  localparam int IDX_W = $clog2(STORE_DEPTH + 1);

  localparam logic [7:0] END_MARK = 8'h00;
  localparam logic [7:0] DELETED_MARK = 8'hE5;
  localparam logic [7:0] LFN_ATTR = 8'h0F;
  localparam logic [7:0] ORDER_BAD_BITS = 8'hA0;
  localparam logic [15:0] PAD_UNIT = 16'hFFFF;
  localparam logic [8:0] MAX_LEN = 9'd255;

  localparam logic [0:0] REG_DATA_START = 1'b0;
  localparam logic [0:0] REG_CLUSTER_SECTORS = 1'b1;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_DECODE  = 9'b000000010,
    S_LONG_WR = 9'b000000100,
    S_SUM     = 9'b000001000,
    S_CHECK   = 9'b000010000,
    S_SCAN    = 9'b000100000,
    S_FINAL   = 9'b001000000,
    S_FILL    = 9'b010000000,
    S_OUT     = 9'b100000000
  } state_t;

  function automatic logic [4:0] unit_pos(input logic [3:0] i);
    logic [4:0] p;
    case (i)
      4'd0: p = 5'd1;
      4'd1: p = 5'd3;
      4'd2: p = 5'd5;
      4'd3: p = 5'd7;
      4'd4: p = 5'd9;
      4'd5: p = 5'd14;
      4'd6: p = 5'd16;
      4'd7: p = 5'd18;
      4'd8: p = 5'd20;
      4'd9: p = 5'd22;
      4'd10: p = 5'd24;
      4'd11: p = 5'd28;
      4'd12: p = 5'd30;
      default: p = 5'd1;
    endcase
    return p;
  endfunction
endpackage
`default_nettype wire

// ----- design/fat_dir_entry_lfn_decoder_core.sv -----
// Top level: FAT directory entry decoder with long file name assembly.
// A long-name entry is stored, a deleted entry dropped, and end of directory gives one word.
// A short entry is checked and its name scanned (the scan is skipped when the check fails),
// then yields its result words one per handshake, each held until out_ready is high.
// One entry is worked at a time; the name store has one read and one write port.
// Reset (rst, synchronous) clears the sequencer, name bookkeeping and data start LBA.
`default_nettype none
module fat_dir_entry_lfn_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] entry_bytes_0_7,
  input  wire logic [63:0] entry_bytes_8_15,
  input  wire logic [63:0] entry_bytes_16_23,
  input  wire logic [63:0] entry_bytes_24_31,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic      [7:0]  attributes,
  output logic      [31:0] first_cluster,
  output logic      [31:0] start_lba,
  output logic      [31:0] size_bytes,
  output logic      [7:0]  long_name_length,
  output logic      [5:0]  chunk_number,
  output logic      [15:0] unit_a,
  output logic      [15:0] unit_b,
  output logic      [15:0] unit_c,
  output logic      [15:0] unit_d,
  output logic             last
);
  localparam int IW = fdl_pkg::IDX_W;

  fdl_pkg::state_t state;
  logic [255:0]  ent;
  logic [31:0]   data_start_lba;
  logic [7:0]    cluster_sectors;
  logic [IW-1:0] slot_count;
  logic [4:0]    expected_order;
  logic [7:0]    name_checksum;
  logic [15:0]   name_mem [fdl_pkg::STORE_DEPTH];
  logic [15:0]   rd_data;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_base;
  logic [3:0]    wr_cnt;
  logic [3:0]    sum_idx;
  logic [7:0]    sum;
  logic [IW-1:0] scan_idx;
  logic [IW-1:0] p_idx;
  logic          p_valid;
  logic          found;
  logic [IW-1:0] name_len;
  logic [6:0]    chunks;
  logic [5:0]    k;
  logic [2:0]    fcnt;
  logic [15:0]   units [4];
  logic [31:0]   lba_calc;
  logic          last_chunk;

  logic [7:0]    b0, b11, b12, b13, b26, b27;
  logic [4:0]    order;
  logic          long_bad;
  logic [IW-1:0] ns_slot;
  logic [4:0]    ns_exp;
  logic [7:0]    ns_chk;
  logic [4:0]    wpos;
  logic [15:0]   wunit;
  logic [IW-1:0] lenv;
  logic [1:0]    fsel;
  logic [7:0]    fu;
  logic [31:0]   ent_cluster;

  assign b0 = ent[7:0];
  assign b11 = ent[95:88];
  assign b12 = ent[103:96];
  assign b13 = ent[111:104];
  assign b26 = ent[215:208];
  assign b27 = ent[223:216];
  assign order = b0[4:0];
  assign long_bad = ((b0 & fdl_pkg::ORDER_BAD_BITS) != 8'd0) || (order == 5'd0)
                    || ({27'd0, order} > fdl_pkg::MAX_NAME_ENTRIES)
                    || (b12 != 8'd0) || (b26 != 8'd0) || (b27 != 8'd0);
  assign ns_slot = b0[6] ? IW'({4'd0, order} * 9'd13) : slot_count;
  assign ns_exp = b0[6] ? order : expected_order;
  assign ns_chk = b0[6] ? b13 : name_checksum;
  assign wpos = fdl_pkg::unit_pos(wr_cnt);
  assign wunit = ent[{wpos, 3'b000} +: 16];
  assign lenv = found ? name_len : slot_count;
  assign fsel = 2'(fcnt - 3'd1);
  assign fu = {k, fsel};
  assign ent_cluster = {ent[175:160], ent[223:208]};
  assign last_chunk = ({1'b0, k} + 7'd1) == chunks;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == fdl_pkg::REG_CLUSTER_SECTORS) ? {24'd0, cluster_sectors}
                                                              : data_start_lba;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_start_lba <= 32'd0;
      cluster_sectors <= 8'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        fdl_pkg::REG_DATA_START: data_start_lba <= pwdata;
        fdl_pkg::REG_CLUSTER_SECTORS: cluster_sectors <= pwdata[7:0];
        default: data_start_lba <= data_start_lba;
      endcase
    end
  end

  fdl_lba_unit u_lba (
    .clk(clk),
    .cluster(ent_cluster),
    .data_start_lba(data_start_lba),
    .cluster_sectors(cluster_sectors),
    .start_lba(lba_calc)
  );

  assign rd_addr = (state == fdl_pkg::S_FILL) ? IW'({k, fcnt[1:0]}) : scan_idx;

  always_ff @(posedge clk) begin
    if (state == fdl_pkg::S_LONG_WR) begin
      name_mem[wr_base + IW'(wr_cnt)] <= wunit;
    end
    rd_data <= name_mem[rd_addr];
  end

  assign in_ready = (state == fdl_pkg::S_IDLE);
  assign out_valid = (state == fdl_pkg::S_OUT);
  assign chunk_number = k;
  assign long_name_length = name_len[7:0];
  assign unit_a = units[0];
  assign unit_b = units[1];
  assign unit_c = units[2];
  assign unit_d = units[3];
  assign last = kind || last_chunk;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fdl_pkg::S_IDLE;
      slot_count <= '0;
      expected_order <= 5'd0;
      name_checksum <= 8'd0;
      p_valid <= 1'b0;
      found <= 1'b0;
      k <= 6'd0;
      fcnt <= 3'd0;
      chunks <= 7'd1;
      kind <= 1'b0;
      name_len <= '0;
    end else begin
      case (state)
        fdl_pkg::S_IDLE: begin
          if (in_valid) begin
            ent <= {entry_bytes_24_31, entry_bytes_16_23, entry_bytes_8_15, entry_bytes_0_7};
            state <= fdl_pkg::S_DECODE;
          end
        end
        fdl_pkg::S_DECODE: begin
          if (b0 == fdl_pkg::END_MARK) begin
            slot_count <= '0;
            kind <= 1'b1;
            attributes <= 8'd0;
            first_cluster <= 32'd0;
            start_lba <= 32'd0;
            size_bytes <= 32'd0;
            name_len <= '0;
            chunks <= 7'd1;
            k <= 6'd0;
            for (int i = 0; i < 4; i++) units[i] <= 16'd0;
            state <= fdl_pkg::S_OUT;
          end else if (b0 == fdl_pkg::DELETED_MARK) begin
            slot_count <= '0;
            state <= fdl_pkg::S_IDLE;
          end else if (b11 == fdl_pkg::LFN_ATTR) begin
            if (long_bad) begin
              slot_count <= '0;
              state <= fdl_pkg::S_IDLE;
            end else if (ns_slot == '0 || ns_exp != order || ns_chk != b13) begin
              expected_order <= ns_exp;
              name_checksum <= ns_chk;
              slot_count <= '0;
              state <= fdl_pkg::S_IDLE;
            end else begin
              name_checksum <= ns_chk;
              slot_count <= ns_slot;
              expected_order <= order - 5'd1;
              wr_base <= IW'({4'd0, order - 5'd1} * 9'd13);
              wr_cnt <= 4'd0;
              state <= fdl_pkg::S_LONG_WR;
            end
          end else begin
            kind <= 1'b0;
            sum <= 8'd0;
            sum_idx <= 4'd0;
            state <= fdl_pkg::S_SUM;
          end
        end
        fdl_pkg::S_LONG_WR: begin
          wr_cnt <= wr_cnt + 4'd1;
          if (wr_cnt == 4'(fdl_pkg::UNITS_PER_ENTRY - 1)) state <= fdl_pkg::S_IDLE;
        end
        fdl_pkg::S_SUM: begin
          sum <= {sum[0], sum[7:1]} + ent[{sum_idx, 3'b000} +: 8];
          sum_idx <= sum_idx + 4'd1;
          if (sum_idx == 4'd10) state <= fdl_pkg::S_CHECK;
        end
        fdl_pkg::S_CHECK: begin
          attributes <= b11;
          first_cluster <= ent_cluster;
          start_lba <= lba_calc;
          size_bytes <= ent[255:224];
          if (slot_count == '0 || expected_order != 5'd0 || b11[3] || sum != name_checksum) begin
            name_len <= '0;
            chunks <= 7'd1;
            slot_count <= '0;
            k <= 6'd0;
            fcnt <= 3'd0;
            state <= fdl_pkg::S_FILL;
          end else begin
            scan_idx <= '0;
            p_valid <= 1'b0;
            found <= 1'b0;
            state <= fdl_pkg::S_SCAN;
          end
        end
        fdl_pkg::S_SCAN: begin
          if (scan_idx < slot_count) begin
            scan_idx <= scan_idx + IW'(1);
            p_idx <= scan_idx;
            p_valid <= 1'b1;
          end else begin
            p_valid <= 1'b0;
          end
          if (p_valid) begin
            if (!found) begin
              if (rd_data == 16'd0) begin
                found <= 1'b1;
                name_len <= p_idx;
              end else if (rd_data == fdl_pkg::PAD_UNIT) begin
                name_len <= '0;
                found <= 1'b1;
                slot_count <= '0;
                state <= fdl_pkg::S_FINAL;
              end
            end else if (rd_data != fdl_pkg::PAD_UNIT) begin
              name_len <= '0;
              slot_count <= '0;
              state <= fdl_pkg::S_FINAL;
            end
          end else if (scan_idx >= slot_count) begin
            state <= fdl_pkg::S_FINAL;
          end
        end
        fdl_pkg::S_FINAL: begin
          if (lenv == '0 || lenv > fdl_pkg::MAX_LEN || slot_count < IW'(13)
              || lenv <= slot_count - IW'(13)) begin
            name_len <= '0;
            chunks <= 7'd1;
          end else begin
            name_len <= lenv;
            chunks <= 7'((lenv + IW'(3)) >> 2);
          end
          slot_count <= '0;
          k <= 6'd0;
          fcnt <= 3'd0;
          state <= fdl_pkg::S_FILL;
        end
        fdl_pkg::S_FILL: begin
          if (fcnt != 3'd0) begin
            units[fsel] <= ({1'b0, fu} < name_len) ? rd_data : 16'd0;
          end
          if (fcnt == 3'd4) begin
            state <= fdl_pkg::S_OUT;
          end else begin
            fcnt <= fcnt + 3'd1;
          end
        end
        fdl_pkg::S_OUT: begin
          if (out_ready) begin
            if (last) begin
              kind <= 1'b0;
              state <= fdl_pkg::S_IDLE;
            end else begin
              k <= k + 6'd1;
              fcnt <= 3'd0;
              state <= fdl_pkg::S_FILL;
            end
          end
        end
        default: state <= fdl_pkg::S_IDLE;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while a word is pending");
  a_next_chunk: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=> (state == fdl_pkg::S_FILL && fcnt == 3'd0))
    else $error("chunk sequence broken");
  a_marker: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind) |-> (long_name_length == 8'd0 && chunk_number == 6'd0 && last))
    else $error("bad end of directory word");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    (state == fdl_pkg::S_FILL) |-> (fcnt <= 3'd4)) else $error("fill counter overrun");
  a_slot_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == fdl_pkg::S_FILL) |-> (slot_count == '0))
    else $error("name not cleared after short entry");
endmodule
`default_nettype wire

// ----- design/fdl_lba_unit.sv -----
// Two-stage start sector calculation from the first cluster number.
`default_nettype none
module fdl_lba_unit (
  input  wire logic        clk,
  input  wire logic [31:0] cluster,
  input  wire logic [31:0] data_start_lba,
  input  wire logic [7:0]  cluster_sectors,
  output logic      [31:0] start_lba
);
  logic [31:0] prod;
  logic        low_cluster;
  logic [31:0] full_prod;

  assign full_prod = (cluster - 32'd2) * {24'd0, cluster_sectors};

  always_ff @(posedge clk) begin
    prod <= full_prod;
    low_cluster <= (cluster < 32'd2);
    start_lba <= low_cluster ? 32'd0 : data_start_lba + prod;
  end
endmodule
`default_nettype wire

// ----- tb/fdl_checker.sv -----
// Checker for the directory entry decoder: predicts result words and compares them.
`default_nettype none
module fdl_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [63:0] entry_bytes_0_7,
  input  wire logic [63:0] entry_bytes_8_15,
  input  wire logic [63:0] entry_bytes_16_23,
  input  wire logic [63:0] entry_bytes_24_31,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        kind,
  input  wire logic [7:0]  attributes,
  input  wire logic [31:0] first_cluster,
  input  wire logic [31:0] start_lba,
  input  wire logic [31:0] size_bytes,
  input  wire logic [7:0]  long_name_length,
  input  wire logic [5:0]  chunk_number,
  input  wire logic [15:0] unit_a,
  input  wire logic [15:0] unit_b,
  input  wire logic [15:0] unit_c,
  input  wire logic [15:0] unit_d,
  input  wire logic        last,
  output int               mismatches,
  output int               pending
);
  typedef struct packed {
    logic             kind;
    logic [7:0]       attributes;
    logic [31:0]      first_cluster;
    logic [31:0]      start_lba;
    logic [31:0]      size_bytes;
    logic [7:0]       name_len;
    logic [5:0]       chunk;
    logic [3:0][15:0] units;
    logic             last;
  } dir_word_t;

  localparam int CHAR_POS [13] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};

  dir_word_t   expected_words[$];
  logic [15:0] name_units[fdl_pkg::STORE_DEPTH];
  int          slots;
  logic [4:0]  next_order;
  logic [7:0]  name_sum;
  logic [31:0] data_start;
  logic [7:0]  clus_sectors;

  function automatic int assembled_length(input logic [7:0] b[32]);
    logic [7:0] sum;
    int len;
    sum = 8'd0;
    len = 0;
    if (slots == 0 || next_order != 0 || b[11][3]) return 0;
    for (int i = 0; i < 11; i++) sum = {sum[0], sum[7:1]} + b[i];
    if (sum != name_sum) return 0;
    while (len < slots && len < fdl_pkg::STORE_DEPTH && name_units[len] != 16'h0000) begin
      if (name_units[len] == fdl_pkg::PAD_UNIT) return 0;
      len++;
    end
    if (len == 0 || len > fdl_pkg::MAX_LEN || slots < fdl_pkg::UNITS_PER_ENTRY ||
        len <= slots - fdl_pkg::UNITS_PER_ENTRY) return 0;
    for (int i = len + 1; i < slots && i < fdl_pkg::STORE_DEPTH; i++)
      if (name_units[i] != fdl_pkg::PAD_UNIT) return 0;
    return len;
  endfunction

  task automatic decode_entry(input logic [255:0] raw);
    logic [7:0]  b[32];
    logic [4:0]  ord;
    logic [31:0] cl;
    logic [31:0] lba;
    dir_word_t   w;
    int          len;
    int          chunks;
    int          u;
    for (int i = 0; i < 32; i++) b[i] = raw[8*i +: 8];
    if (b[0] == fdl_pkg::END_MARK) begin
      slots = 0;
      w = '0;
      w.kind = 1'b1;
      w.last = 1'b1;
      expected_words.push_back(w);
    end else if (b[0] == fdl_pkg::DELETED_MARK) begin
      slots = 0;
    end else if (b[11] == fdl_pkg::LFN_ATTR) begin
      ord = b[0][4:0];
      if ((b[0] & fdl_pkg::ORDER_BAD_BITS) != 0 || ord == 0 ||
          ord > fdl_pkg::MAX_NAME_ENTRIES ||
          b[12] != 0 || b[26] != 0 || b[27] != 0) begin
        slots = 0;
      end else begin
        if (b[0][6]) begin
          slots = ord * fdl_pkg::UNITS_PER_ENTRY;
          next_order = ord;
          name_sum = b[13];
        end
        if (slots == 0 || next_order != ord || name_sum != b[13]) begin
          slots = 0;
        end else begin
          for (int i = 0; i < fdl_pkg::UNITS_PER_ENTRY; i++)
            name_units[(ord - 1) * fdl_pkg::UNITS_PER_ENTRY + i] =
              {b[CHAR_POS[i] + 1], b[CHAR_POS[i]]};
          next_order = next_order - 5'd1;
        end
      end
    end else begin
      len = assembled_length(b);
      slots = 0;
      cl = {b[21], b[20], b[27], b[26]};
      lba = (cl >= 2) ? data_start + (cl - 32'd2) * clus_sectors : 32'd0;
      chunks = (len + 3) / 4;
      if (chunks == 0) chunks = 1;
      for (int k = 0; k < chunks; k++) begin
        w.kind = 1'b0;
        w.attributes = b[11];
        w.first_cluster = cl;
        w.start_lba = lba;
        w.size_bytes = {b[31], b[30], b[29], b[28]};
        w.name_len = len[7:0];
        w.chunk = k[5:0];
        for (int i = 0; i < 4; i++) begin
          u = k * 4 + i;
          w.units[3 - i] = (u < len) ? name_units[u] : 16'h0000;
        end
        w.last = (k + 1 == chunks);
        expected_words.push_back(w);
      end
    end
  endtask

  always @(posedge clk) begin
    dir_word_t got;
    dir_word_t want;
    if (rst) begin
      expected_words.delete();
      slots = 0;
      next_order = '0;
      name_sum = '0;
      data_start = '0;
      clus_sectors = 8'd1;
      mismatches <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == fdl_pkg::REG_DATA_START) data_start = pwdata;
        else clus_sectors = pwdata[7:0];
      end
      if (in_valid && in_ready)
        decode_entry({entry_bytes_24_31, entry_bytes_16_23, entry_bytes_8_15, entry_bytes_0_7});
      if (out_valid && out_ready) begin
        got = {kind, attributes, first_cluster, start_lba, size_bytes, long_name_length,
               chunk_number, unit_a, unit_b, unit_c, unit_d, last};
        if (expected_words.size() == 0) begin
          if (mismatches < 10) $display("Unexpected word: %p", got);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            if (mismatches < 10) $display("Mismatch: expected %p, got %p", want, got);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    pending <= expected_words.size();
  end
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench top: drives directory entries and register writes, and gives the verdict.
`default_nettype none
module tb_top;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int CHAR_POS [13] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};

  localparam int FAULT_NONE = 0;
  localparam int FAULT_DIR_ATTR = 1;
  localparam int FAULT_EARLY_PAD = 2;
  localparam int FAULT_BAD_PAD = 3;
  localparam int FAULT_BAD_SUM = 4;
  localparam int FAULT_MISSING = 5;
  localparam int FAULT_DELETED = 6;
  localparam int FAULT_RESERVED = 7;
  localparam int FAULT_ONE_SUM = 8;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] entry_bytes_0_7;
  logic [63:0] entry_bytes_8_15;
  logic [63:0] entry_bytes_16_23;
  logic [63:0] entry_bytes_24_31;
  logic        out_valid;
  logic        out_ready;
  logic        kind;
  logic [7:0]  attributes;
  logic [31:0] first_cluster;
  logic [31:0] start_lba;
  logic [31:0] size_bytes;
  logic [7:0]  long_name_length;
  logic [5:0]  chunk_number;
  logic [15:0] unit_a;
  logic [15:0] unit_b;
  logic [15:0] unit_c;
  logic [15:0] unit_d;
  logic        last;
  int          mismatches;
  int          pending;
  int          cycles;
  int          burst_left;
  int          entries_sent;
  int          ready_mode;
  int          mode_left;

  fat_dir_entry_lfn_decoder_core u_top (.*);
  fdl_checker u_checker (.*);

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst) cycles <= 0;
    else cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      ready_mode <= 0;
      mode_left <= 0;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  function automatic logic [255:0] random_entry();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [7:0] short_name_sum(input logic [255:0] e);
    logic [7:0] sum;
    sum = 8'd0;
    for (int i = 0; i < 11; i++) sum = {sum[0], sum[7:1]} + e[8*i +: 8];
    return sum;
  endfunction

  task automatic send_entry(input logic [255:0] e);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    {entry_bytes_24_31, entry_bytes_16_23, entry_bytes_8_15, entry_bytes_0_7} <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    entries_sent++;
  endtask

  task automatic send_named_file(input int n, input int len, input int fault,
                                 input bit small_cluster);
    logic [255:0] sh;
    logic [255:0] lf;
    logic [15:0]  units[fdl_pkg::STORE_DEPTH];
    logic [7:0]   sum;
    int           pick;
    sh = random_entry();
    do sh[7:0] = 8'($urandom_range(1, 255)); while (sh[7:0] == fdl_pkg::DELETED_MARK);
    sh[95:88] = 8'($urandom) & 8'hF7;
    if (fault == FAULT_DIR_ATTR) sh[91] = 1'b1;
    if (small_cluster) begin
      sh[175:160] = 16'h0000;
      sh[223:208] = 16'($urandom_range(0, 3));
    end
    for (int i = 0; i < n * fdl_pkg::UNITS_PER_ENTRY; i++) begin
      if (i < len) units[i] = 16'($urandom_range(1, 16'hFFFE));
      else if (i == len) units[i] = 16'h0000;
      else units[i] = fdl_pkg::PAD_UNIT;
    end
    if (fault == FAULT_EARLY_PAD) units[$urandom_range(0, len - 1)] = fdl_pkg::PAD_UNIT;
    if (fault == FAULT_BAD_PAD && len + 1 < n * fdl_pkg::UNITS_PER_ENTRY)
      units[len + 1] = 16'($urandom_range(0, 16'hFFFE));
    sum = short_name_sum(sh);
    if (fault == FAULT_BAD_SUM) sum = sum ^ 8'h5A;
    pick = $urandom_range(1, n);
    for (int ord = n; ord >= 1; ord--) begin
      if (!(fault == FAULT_MISSING && ord == pick)) begin
        lf = random_entry();
        lf[7:0] = ord[7:0] | ((ord == n) ? 8'h40 : 8'h00);
        lf[95:88] = fdl_pkg::LFN_ATTR;
        lf[103:96] = (fault == FAULT_RESERVED && ord == pick) ?
                     8'h01 << $urandom_range(0, 7) : 8'h00;
        lf[111:104] = (fault == FAULT_ONE_SUM && ord == pick) ? sum ^ 8'h01 : sum;
        lf[223:208] = 16'h0000;
        for (int i = 0; i < fdl_pkg::UNITS_PER_ENTRY; i++)
          lf[8*CHAR_POS[i] +: 16] = units[(ord - 1) * fdl_pkg::UNITS_PER_ENTRY + i];
        send_entry(lf);
      end
    end
    if (fault == FAULT_DELETED) begin
      lf = random_entry();
      lf[7:0] = fdl_pkg::DELETED_MARK;
      send_entry(lf);
    end
    send_entry(sh);
  endtask

  task automatic send_odd_entry();
    logic [255:0] e;
    e = random_entry();
    case ($urandom_range(0, 5))
      0: e[7:0] = fdl_pkg::END_MARK;
      1: e[7:0] = fdl_pkg::DELETED_MARK;
      2: e[95:88] = fdl_pkg::LFN_ATTR;
      3: begin
        e[95:88] = fdl_pkg::LFN_ATTR;
        e[7:0] = 8'($urandom) & 8'h5F;
        e[103:96] = 8'h00;
        e[223:208] = 16'h0000;
      end
      default: begin
        if (e[7:0] == fdl_pkg::END_MARK || e[7:0] == fdl_pkg::DELETED_MARK) e[7:0] = 8'h41;
        if (e[95:88] == fdl_pkg::LFN_ATTR) e[95:88] = 8'h20;
      end
    endcase
    send_entry(e);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic apb_write(input logic [0:0] index, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_file();
    int n;
    int len;
    int fault;
    n = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 4) : $urandom_range(5, 20);
    if ($urandom_range(0, 4) == 0) len = $urandom_range(1, n * fdl_pkg::UNITS_PER_ENTRY);
    else len = (n - 1) * fdl_pkg::UNITS_PER_ENTRY + $urandom_range(1, fdl_pkg::UNITS_PER_ENTRY);
    fault = ($urandom_range(0, 3) == 0) ? $urandom_range(FAULT_DIR_ATTR, FAULT_ONE_SUM)
                                        : FAULT_NONE;
    send_named_file(n, len, fault, $urandom_range(0, 3) == 0);
  endtask

  initial begin
    logic [255:0] e;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    {entry_bytes_24_31, entry_bytes_16_23, entry_bytes_8_15, entry_bytes_0_7} <= '0;
    burst_left = 0;
    entries_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_write(fdl_pkg::REG_DATA_START, 32'h0000_0000);
    apb_write(fdl_pkg::REG_CLUSTER_SECTORS, 32'd1);

    send_entry('0);
    e = random_entry();
    e[7:0] = fdl_pkg::END_MARK;
    send_entry(e);
    e[7:0] = fdl_pkg::DELETED_MARK;
    send_entry(e);
    e = '1;
    e[95:88] = 8'h10;
    send_entry(e);
    e = random_entry();
    e[7:0] = 8'h41;
    e[95:88] = fdl_pkg::LFN_ATTR;
    e[103:96] = 8'h00;
    e[223:208] = 16'h0000;
    send_entry(e);
    e[7:0] = 8'h40;
    send_entry(e);
    e[7:0] = 8'h55;
    send_entry(e);
    e[7:0] = 8'h01;
    send_entry(e);
    e[7:0] = 8'h20;
    e[95:88] = 8'h00;
    send_entry(e);
    send_named_file(1, 1, FAULT_NONE, 1'b1);
    send_named_file(1, 13, FAULT_NONE, 1'b0);
    send_named_file(2, 5, FAULT_NONE, 1'b0);
    send_named_file(20, 255, FAULT_NONE, 1'b0);
    wait_drained();
    send_named_file(20, 256, FAULT_NONE, 1'b0);
    for (int f = FAULT_DIR_ATTR; f <= FAULT_ONE_SUM; f++) send_named_file(3, 30, f, 1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          apb_write(fdl_pkg::REG_DATA_START, 32'hFFFF_FFFF);
          apb_write(fdl_pkg::REG_CLUSTER_SECTORS, 32'd128);
        end
        1: begin
          apb_write(fdl_pkg::REG_DATA_START, $urandom);
          apb_write(fdl_pkg::REG_CLUSTER_SECTORS, $urandom_range(1, 128));
        end
        2: begin
          apb_write(fdl_pkg::REG_DATA_START, $urandom);
          apb_write(fdl_pkg::REG_CLUSTER_SECTORS, 32'd1);
        end
        default: begin
          apb_write(fdl_pkg::REG_DATA_START, 32'h0000_0000);
          apb_write(fdl_pkg::REG_CLUSTER_SECTORS, $urandom_range(1, 128));
        end
      endcase
      entries_sent = 0;
      while (entries_sent < 75) begin
        if ($urandom_range(0, 4) == 0) send_odd_entry();
        else send_random_file();
      end
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
